// ===== src/float_reciprocal_rsqrt_unit_assert.svh =====
// assertion macros for the float reciprocal / rsqrt unit
// expects clk and rst_n in the scope where a macro is used
`ifndef FLOAT_RECIPROCAL_RSQRT_UNIT_ASSERT_SVH
`define FLOAT_RECIPROCAL_RSQRT_UNIT_ASSERT_SVH

// same-cycle implication
`define FRRS_ASSERT_IMP(name, ant, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("frrs assertion failed");

// next-cycle implication
`define FRRS_ASSERT_NXT(name, ant, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("frrs assertion failed");

`endif

// ===== src/frrs_pkg.sv =====
// types, constants and rounding helpers for the float reciprocal / rsqrt unit
// no dependencies; used by frrs_lane and float_reciprocal_rsqrt_unit
`timescale 1ns / 1ps

package frrs_pkg;

    localparam int SQ_STEPS = 27;
    localparam int DV_STEPS = 28;
    localparam int CI_SPA   = 2 + SQ_STEPS;
    localparam int LANE_LAT = CI_SPA + 5 + DV_STEPS;
    localparam int CI_PA    = LANE_LAT - 2;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

    localparam logic OP_RCP = 1'b0;
    localparam logic OP_RSQ = 1'b1;

    typedef struct packed {
        logic [23:0]        m;
        logic signed [9:0]  e;
    } unp_t;

    typedef struct packed {
        logic               sign;
        logic [23:0]        kept;
        logic               inc;
        logic signed [10:0] biased;
    } rnd_t;

    typedef struct packed {
        logic        byp;
        logic [31:0] bval;
        logic        op;
        logic        sign;
    } ctl_t;

    typedef struct packed {
        logic [27:0]       rem;
        logic [26:0]       root;
        logic [25:0]       nb;
        logic signed [9:0] exp2;
        unp_t              x;
    } sq_t;

    typedef struct packed {
        logic [23:0]       p;
        logic [27:0]       q;
        logic [23:0]       m;
        logic signed [9:0] exp2;
        logic              sign;
    } dv_t;

    // finite nonzero magnitude to 24-bit significand with hidden bit set
    function automatic unp_t unpack(input logic [30:0] mag);
        unp_t       u;
        logic [4:0] msb;
        logic [4:0] s;
        msb = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (mag[i])
                msb = 5'(i);
        end
        s = 5'd23 - msb;
        if (mag[30:23] != 8'd0)
        begin
            u.m = {1'b1, mag[22:0]};
            u.e = $signed({2'b00, mag[30:23]});
        end
        else
        begin
            u.m = 24'({1'b0, mag[22:0]} << s);
            u.e = 10'sd1 - $signed({5'b00000, s});
        end
        return u;
    endfunction

    function automatic sq_t sqrt_seed(input unp_t u);
        sq_t               a;
        logic signed [9:0] t;
        logic [24:0]       m25;
        t = u.e - 10'sd150;
        if (t[0])
        begin
            m25 = {u.m, 1'b0};
            t   = t - 10'sd1;
        end
        else
            m25 = {1'b0, u.m};
        a.rem  = '0;
        a.root = '0;
        a.nb   = {1'b0, m25};
        a.exp2 = (t >>> 1) - 10'sd14;
        a.x    = u;
        return a;
    endfunction

    // one root bit per step, two radicand bits in
    function automatic sq_t sqrt_step(input sq_t a);
        sq_t         b;
        logic [29:0] r3;
        logic [29:0] trial;
        b     = a;
        r3    = {a.rem, a.nb[25:24]};
        trial = {1'b0, a.root, 2'b01};
        if (r3 >= trial)
        begin
            b.rem  = 28'(r3 - trial);
            b.root = {a.root[25:0], 1'b1};
        end
        else
        begin
            b.rem  = r3[27:0];
            b.root = {a.root[25:0], 1'b0};
        end
        b.nb = {a.nb[23:0], 2'b00};
        return b;
    endfunction

    // one quotient bit per step
    function automatic dv_t div_step(input dv_t a);
        dv_t         b;
        logic [24:0] p2;
        b  = a;
        p2 = {a.p, 1'b0};
        if (p2 >= {1'b0, a.m})
        begin
            b.p = 24'(p2 - {1'b0, a.m});
            b.q = {a.q[26:0], 1'b1};
        end
        else
        begin
            b.p = p2[23:0];
            b.q = {a.q[26:0], 1'b0};
        end
        return b;
    endfunction

    // value is sig * 2^exp2, sticky flags nonzero bits below sig
    function automatic rnd_t pack_pre(input logic [27:0] sig, input logic signed [9:0] exp2,
                                      input logic sticky, input logic sign);
        rnd_t               r;
        logic [4:0]         len;
        logic signed [10:0] sh;
        logic signed [10:0] alt;
        logic [4:0]         s5;
        logic [31:0]        sig32;
        logic [31:0]        kept32;
        logic [31:0]        rem;
        logic [31:0]        half;
        len = '0;
        for (int i = 0; i < 28; i++)
        begin
            if (sig[i])
                len = 5'(i + 1);
        end
        sh  = $signed({6'b000000, len}) - 11'sd24;
        alt = -11'sd149 - 11'(exp2);
        if (alt > sh)
            sh = alt;
        if (sh < 0)
            s5 = '0;
        else if (sh > 11'sd31)
            s5 = 5'd31;
        else
            s5 = sh[4:0];
        sig32  = {4'b0000, sig};
        kept32 = sig32 >> s5;
        rem    = sig32 & ((32'h1 << s5) - 32'h1);
        half   = (s5 == 5'd0) ? 32'h0 : (32'h1 << (s5 - 5'd1));
        r.sign   = sign;
        r.kept   = kept32[23:0];
        r.inc    = (s5 != 5'd0) && ((rem > half) || ((rem == half) && (sticky || kept32[0])));
        r.biased = 11'(exp2) + $signed({6'b000000, s5}) + 11'sd150;
        return r;
    endfunction

    function automatic logic [31:0] pack_fin(input rnd_t r);
        logic [24:0]        k;
        logic signed [10:0] b;
        logic [31:0]        res;
        k = {1'b0, r.kept} + 25'(r.inc);
        b = r.biased;
        if (k[24])
        begin
            k = k >> 1;
            b = b + 11'sd1;
        end
        if (k[23])
        begin
            if (b >= 11'sd255)
                res = {r.sign, INF_MAG};
            else
                res = {r.sign, b[7:0], k[22:0]};
        end
        else
            res = {r.sign, 8'd0, k[22:0]};
        return res;
    endfunction

endpackage

// ===== src/float_reciprocal_rsqrt_unit.sv =====
// float32 reciprocal and reciprocal square root, up to four lanes per item
// depends on frrs_pkg, frrs_lane and float_reciprocal_rsqrt_unit_assert.svh
//
// usage:
//   s_* channel takes one item: s_tuser = {scalar, op}, op 0 = 1/x, 1 = 1/sqrt(x);
//   s_tdata = four source lanes then old destination lanes 1-3
//   m_* channel returns four result lanes in m_tdata, lane 0 in the low bits
//   each lane runs a 27-step root pipeline then a 28-step divide pipeline
//   throughput is one item per cycle while the receiver does not stall; the whole pipeline advances together
//   scalar items compute lane 0 and return the old destination in lanes 1-3;
//   lanes at or above LANE_COUNT always return the old destination
//   reset empties the pipeline and drops m_tvalid; no other setup is needed
//   when the receiver stalls with a result held in the output register the
//   pipeline freezes and s_tready drops until the result is taken
`timescale 1ns / 1ps

module float_reciprocal_rsqrt_unit #(
    parameter int LANE_COUNT = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,  // source_lane_0..3, old_dest_lane_1..3
    input  logic [1:0]   s_tuser,  // op, scalar
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // result_lane_0..3
);
    import frrs_pkg::*;

    logic                en;
    logic                op;
    logic                scalar;
    logic [LANE_LAT-1:0] vld_reg;
    logic                m_tvalid_reg;
    logic [127:0]        m_tdata_reg;
    logic [31:0]         lane_res [4];

    assign op       = s_tuser[0];
    assign scalar   = s_tuser[1];
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        if (i < LANE_COUNT)
        begin : g_core
            frrs_lane u_lane (
                .clk    (clk),
                .en     (en),
                .op     (op),
                .active ((i == 0) || !scalar),
                .x      (s_tdata[32*i +: 32]),
                .old    ((i == 0) ? 32'd0 : s_tdata[32*(i+3) +: 32]),
                .result (lane_res[i])
            );
        end
        else
        begin : g_pass
            logic [31:0] dly_reg [LANE_LAT];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dly_reg[0] <= s_tdata[32*(i+3) +: 32];
                    for (int k = 1; k < LANE_LAT; k++)
                        dly_reg[k] <= dly_reg[k-1];
                end
            end
            assign lane_res[i] = dly_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[LANE_LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    // merge the lanes into the output item
    always_ff @(posedge clk)
    begin
        if (en)
            m_tdata_reg <= {lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "float_reciprocal_rsqrt_unit_assert.svh"

    `FRRS_ASSERT_NXT(a_out_load, en && vld_reg[LANE_LAT-1], m_tvalid)
    `FRRS_ASSERT_NXT(a_stall_freeze, !en, $stable(vld_reg) && m_tvalid)
    `FRRS_ASSERT_IMP(a_no_take_in_stall, m_tvalid && !m_tready, !s_tready)

endmodule

// ===== src/frrs_lane.sv =====
// one lane: special-case decode, pipelined square root, pipelined reciprocal
// depends on frrs_pkg
`timescale 1ns / 1ps

module frrs_lane (
    input  logic        clk,
    input  logic        en,
    input  logic        op,
    input  logic        active,
    input  logic [31:0] x,
    input  logic [31:0] old,
    output logic [31:0] result
);
    import frrs_pkg::*;

    ctl_t        ctl_next;
    ctl_t        ctl_reg [LANE_LAT-1];
    unp_t        u_reg;
    sq_t         p_reg;
    sq_t         sq_reg [SQ_STEPS];
    rnd_t        spa_reg;
    unp_t        spax_reg;
    logic [31:0] spb_reg;
    unp_t        spbx_reg;
    dv_t         u2_next;
    dv_t         u2_reg;
    dv_t         dv_reg [DV_STEPS];
    rnd_t        pa_reg;
    logic [31:0] res_reg;
    logic [30:0] mag;

    assign mag = x[30:0];

    always_comb
    begin
        ctl_next.op   = op;
        ctl_next.sign = x[31];
        ctl_next.byp  = 1'b1;
        ctl_next.bval = '0;
        if (!active)
            ctl_next.bval = old;
        else if (mag > INF_MAG)
            ctl_next.bval = x | QUIET_BIT;
        else if (mag == 31'd0)
            ctl_next.bval = {x[31], INF_MAG};
        else if (op == OP_RCP && mag == INF_MAG)
            ctl_next.bval = {x[31], 31'd0};
        else if (op == OP_RSQ && x[31])
            ctl_next.bval = DEFAULT_NAN;
        else if (op == OP_RSQ && mag == INF_MAG)
            ctl_next.bval = '0;
        else
            ctl_next.byp = 1'b0;
    end

    // reciprocal operand: the rounded root for rsqrt, the unpacked source otherwise
    always_comb
    begin
        u2_next.p = 24'h40_0000;
        u2_next.q = '0;
        if (ctl_reg[CI_SPA+1].op == OP_RSQ)
        begin
            u2_next.m    = {1'b1, spb_reg[22:0]};
            u2_next.exp2 = 10'sd100 - $signed({2'b00, spb_reg[30:23]});
            u2_next.sign = 1'b0;
        end
        else
        begin
            u2_next.m    = spbx_reg.m;
            u2_next.exp2 = 10'sd100 - spbx_reg.e;
            u2_next.sign = ctl_reg[CI_SPA+1].sign;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < LANE_LAT - 1; i++)
                ctl_reg[i] <= ctl_reg[i-1];
            u_reg     <= unpack(mag);
            p_reg     <= sqrt_seed(u_reg);
            sq_reg[0] <= sqrt_step(p_reg);
            for (int i = 1; i < SQ_STEPS; i++)
                sq_reg[i] <= sqrt_step(sq_reg[i-1]);
            spa_reg   <= pack_pre({1'b0, sq_reg[SQ_STEPS-1].root}, sq_reg[SQ_STEPS-1].exp2,
                                  sq_reg[SQ_STEPS-1].rem != 28'd0, 1'b0);
            spax_reg  <= sq_reg[SQ_STEPS-1].x;
            spb_reg   <= pack_fin(spa_reg);
            spbx_reg  <= spax_reg;
            u2_reg    <= u2_next;
            dv_reg[0] <= div_step(u2_reg);
            for (int i = 1; i < DV_STEPS; i++)
                dv_reg[i] <= div_step(dv_reg[i-1]);
            pa_reg    <= pack_pre(dv_reg[DV_STEPS-1].q, dv_reg[DV_STEPS-1].exp2,
                                  dv_reg[DV_STEPS-1].p != 24'd0, dv_reg[DV_STEPS-1].sign);
            res_reg   <= ctl_reg[CI_PA].byp ? ctl_reg[CI_PA].bval : pack_fin(pa_reg);
        end
    end

    assign result = res_reg;

endmodule
